// File: rtl/core/frma_pkg.sv
package frma_pkg;

	localparam int TS_W       = 32;
	localparam int INTERVAL_W = 16;
	localparam int RATE_W     = 24;
	localparam int FRAMES_W   = 24;
	localparam int HELD_W     = 4;
	localparam int SCALE_W    = 18;
	localparam int DIVIDEND_W = FRAMES_W + SCALE_W;
	localparam int DIVISOR_W  = TS_W;
	localparam int DIV_CNT_W  = 6;

	// frames * 1000 ms/s * 256 for the q8 fraction
	localparam logic [SCALE_W-1:0]    RATE_SCALE     = 18'd256000;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
	localparam logic [RATE_W-1:0]     RATE_MAX       = {RATE_W{1'b1}};
	localparam logic [FRAMES_W-1:0]   FRAMES_MAX     = {FRAMES_W{1'b1}};

	typedef struct packed {
		logic accept;
		logic mul;
		logic div_start;
		logic div_avg;
		logic ring_write;
		logic sum_read;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic close;
		logic div_busy;
		logic div_done;
		logic rd_last;
	} dp_status_t;

endpackage

// File: rtl/core/frma_div.sv
module frma_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [frma_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [frma_pkg::DIVISOR_W-1:0]   divisor,
	input  logic [frma_pkg::DIV_CNT_W-1:0]   steps,
	output logic                             busy,
	output logic                             done,
	output logic [frma_pkg::DIVIDEND_W-1:0]  quotient
);
	import frma_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;

	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;
	logic [DIVISOR_W-1:0]  rem_next;

	// restoring division, one quotient bit per cycle from the dividend msb down
	always_comb begin
		shifted  = {rem_q, dvd_q[DIVIDEND_W-1]};
		diff     = shifted - {1'b0, dsr_q};
		ge       = (shifted >= {1'b0, dsr_q});
		rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], 1'b0};
			rem_q <= rem_next;
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/core/frma_datapath.sv
module frma_datapath #(
	parameter int RING_DEPTH = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [frma_pkg::INTERVAL_W-1:0]  cfg_interval,
	input  logic [frma_pkg::TS_W-1:0]        timestamp_ms,
	input  frma_pkg::dp_cmd_t                cmd,
	output frma_pkg::dp_status_t             st,
	output logic [frma_pkg::RATE_W-1:0]      latest_rate_q8,
	output logic [frma_pkg::RATE_W-1:0]      average_rate_q8,
	output logic [frma_pkg::HELD_W-1:0]      samples_held
);
	import frma_pkg::*;

	localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int IDX_W  = CNT_W + 1;
	localparam int SUM_W  = RATE_W + CNT_W;

	logic [INTERVAL_W-1:0] interval_q;
	logic                  started_q;
	logic [TS_W-1:0]       start_q;
	logic [FRAMES_W-1:0]   frames_q;
	logic [TS_W-1:0]       elapsed_q;
	logic [FRAMES_W-1:0]   close_frames_q;
	logic [DIVIDEND_W-1:0] product_q;
	logic [RATE_W-1:0]     rate_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [CNT_W-1:0]      fill_q;
	logic [SLOT_W-1:0]     rd_idx_q;
	logic                  rd_valid_s1;
	logic [RATE_W-1:0]     rd_data_s1;
	logic [SUM_W-1:0]      sum_q;
	logic [RATE_W-1:0]     latest_q;
	logic [RATE_W-1:0]     avg_q;
	logic [HELD_W-1:0]     held_q;

	logic [RATE_W-1:0]     ring_mem [RING_DEPTH];

	logic [TS_W-1:0]        win_start;
	logic [FRAMES_W-1:0]    frames_inc;
	logic [TS_W-1:0]        elapsed;
	logic [DIVIDEND_W-1:0]  product_c;
	logic [DIVIDEND_W-1:0]  div_dividend;
	logic [DIVISOR_W-1:0]   div_divisor;
	logic [DIV_CNT_W-1:0]   div_steps;
	logic [DIVIDEND_W-1:0]  quo;
	logic                   div_busy;
	logic                   div_done;
	logic [RATE_W-1:0]      rate_sat;
	logic [CNT_W+HELD_W-1:0] held_ext;

	always_comb begin
		win_start  = started_q ? start_q : timestamp_ms;
		frames_inc = (frames_q == FRAMES_MAX) ? frames_q : frames_q + 1'b1;
		elapsed    = timestamp_ms - win_start;
		product_c  = DIVIDEND_W'(close_frames_q) * DIVIDEND_W'(RATE_SCALE);
		rate_sat   = (|quo[DIVIDEND_W-1:RATE_W]) ? RATE_MAX : quo[RATE_W-1:0];
		held_ext   = {{HELD_W{1'b0}}, fill_q};
		// the sum is left-aligned so only its own bit count needs stepping
		if (cmd.div_avg) begin
			div_dividend = {sum_q, {(DIVIDEND_W-SUM_W){1'b0}}};
			div_divisor  = DIVISOR_W'(fill_q);
			div_steps    = DIV_CNT_W'(SUM_W);
		end else begin
			div_dividend = product_q;
			div_divisor  = elapsed_q;
			div_steps    = DIV_CNT_W'(DIVIDEND_W);
		end
	end

	frma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		st.close    = (elapsed > TS_W'(interval_q));
		st.div_busy = div_busy;
		st.div_done = div_done;
		st.rd_last  = ((IDX_W'(rd_idx_q) + IDX_W'(1)) == IDX_W'(fill_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= INTERVAL_RESET;
			started_q   <= 1'b0;
			start_q     <= '0;
			frames_q    <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.sum_read;
			if (cfg_we) begin
				interval_q <= cfg_interval;
			end
			if (cmd.accept) begin
				started_q <= 1'b1;
				if (st.close) begin
					start_q  <= timestamp_ms;
					frames_q <= '0;
				end else begin
					start_q  <= win_start;
					frames_q <= frames_inc;
				end
			end
			if (cmd.ring_write) begin
				slot_q <= (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
				if (fill_q != CNT_W'(RING_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			elapsed_q      <= elapsed;
			close_frames_q <= frames_inc;
		end
		if (cmd.mul) begin
			product_q <= product_c;
		end
		if (cmd.ring_write) begin
			rate_q   <= rate_sat;
			rd_idx_q <= '0;
			sum_q    <= '0;
		end else begin
			if (cmd.sum_read) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (rd_valid_s1) begin
				sum_q <= sum_q + SUM_W'(rd_data_s1);
			end
		end
		if (cmd.out_load) begin
			latest_q <= rate_q;
			avg_q    <= quo[RATE_W-1:0];
			held_q   <= held_ext[HELD_W-1:0];
		end
	end

	// rate ring, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.ring_write) begin
			ring_mem[slot_q] <= rate_sat;
		end
		if (cmd.sum_read) begin
			rd_data_s1 <= ring_mem[rd_idx_q];
		end
	end

	assign latest_rate_q8  = latest_q;
	assign average_rate_q8 = avg_q;
	assign samples_held    = held_q;

endmodule

// File: rtl/core/frma_ctrl.sv
module frma_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  frma_pkg::dp_status_t  st,
	output frma_pkg::dp_cmd_t     cmd
);
	import frma_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_RDIV,
		S_RDIV_WAIT,
		S_WRITE,
		S_SUM_RD,
		S_SUM_LAST,
		S_ADIV,
		S_ADIV_WAIT,
		S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.accept     = accept;
		cmd.mul        = (state_q == S_MUL);
		cmd.div_start  = (state_q == S_RDIV) || (state_q == S_ADIV);
		cmd.div_avg    = (state_q == S_ADIV);
		cmd.ring_write = (state_q == S_WRITE);
		cmd.sum_read   = (state_q == S_SUM_RD);
		cmd.out_load   = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && st.close) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:       state_q <= S_RDIV;
				S_RDIV:      state_q <= S_RDIV_WAIT;
				S_RDIV_WAIT: begin
					if (st.div_done) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE:     state_q <= S_SUM_RD;
				S_SUM_RD: begin
					if (st.rd_last) begin
						state_q <= S_SUM_LAST;
					end
				end
				// last read word still needs its add
				S_SUM_LAST:  state_q <= S_ADIV;
				S_ADIV:      state_q <= S_ADIV_WAIT;
				S_ADIV_WAIT: begin
					if (st.div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default:     state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/frame_rate_moving_average.sv
// channel  | signals                                        | word
// ---------+------------------------------------------------+------------------------------
// in       | in_valid, in_ready, timestamp_ms               | one frame event
// out      | out_valid, out_ready, latest_rate_q8,          | one closed window
//          | average_rate_q8, samples_held                  |
// cfg      | cfg_valid, cfg_ready, interval_ms              | window length in ms
//
// an event that does not close a window leaves the core idle; in_ready stays high
// a closing event holds in_ready low while the shared one-bit-per-cycle divider works out
// the 42-bit rate quotient, the ring is read once per entry to sum it, and the divider
// then steps the 24 + ceil(log2(RING_DEPTH+1)) bits of that sum for the average
// the result sits in an output register; the next close stalls until it is taken
// asynchronous reset clears window, counters, ring write slot and fill count; ring data needs none
module frame_rate_moving_average #(
	parameter int RING_DEPTH = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [frma_pkg::TS_W-1:0]        timestamp_ms,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [frma_pkg::RATE_W-1:0]      latest_rate_q8,
	output logic [frma_pkg::RATE_W-1:0]      average_rate_q8,
	output logic [frma_pkg::HELD_W-1:0]      samples_held,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [frma_pkg::INTERVAL_W-1:0]  interval_ms
);
	import frma_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	assign cfg_ready = 1'b1;

	frma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	frma_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid),
		.cfg_interval    (interval_ms),
		.timestamp_ms    (timestamp_ms),
		.cmd             (cmd),
		.st              (st),
		.latest_rate_q8  (latest_rate_q8),
		.average_rate_q8 (average_rate_q8),
		.samples_held    (samples_held)
	);

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.mul, cmd.div_start, cmd.ring_write, cmd.sum_read,
			cmd.out_load}))
		else $error("datapath commands overlap");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !st.div_busy)
		else $error("divider started while busy");

	a_no_input_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_busy |-> !in_ready)
		else $error("input taken during division");

	a_held_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> samples_held != '0)
		else $error("result with empty average");

endmodule
